FILE: rtl/mrq_pkg.sv
// Shared types and constants for the multilevel ready queue.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package mrq_pkg;

  localparam int NUM_LEVELS_DEF = 32;
  localparam int MAX_TASKS_DEF  = 64;

  localparam int ID_W      = 6;
  localparam int PRIO_W    = 5;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 8;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_WR,
    ST_DEQ_LINK,
    ST_DEQ_WR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic ins_wr;
    logic deq_wr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_dequeue;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/mrq_ctrl.sv
// Controller of the multilevel ready queue: sequences one word at a time.
// Depends on mrq_pkg for the state, command and status types.
`timescale 1ns / 1ps

module mrq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  mrq_pkg::status_t status,
  output mrq_pkg::cmd_t    cmd
);
  import mrq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = status.op_dequeue ? ST_DEQ_LINK : ST_INS_WR;
        end
      end
      ST_INS_WR:   state_next = ST_IDLE;
      ST_DEQ_LINK: state_next = ST_DEQ_WR;
      ST_DEQ_WR: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.ins_wr = 1'b0;
    cmd.deq_wr = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_INS_WR:   cmd.ins_wr = 1'b1;
      ST_DEQ_LINK: cmd.deq_wr = 1'b0;
      ST_DEQ_WR:   cmd.deq_wr = status.out_free;
      default:     cmd.deq_wr = 1'b0;
    endcase
  end

endmodule

FILE: rtl/mrq_datapath.sv
// Datapath of the multilevel ready queue: head, tail and link memories,
// the non-empty bits with their priority encoder, and the output register.
// Depends on mrq_pkg for widths and the command and status types.
`timescale 1ns / 1ps

module mrq_datapath #(
  parameter int NUM_LEVELS = mrq_pkg::NUM_LEVELS_DEF,
  parameter int MAX_TASKS  = mrq_pkg::MAX_TASKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mrq_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  output logic [mrq_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                            m_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  mrq_pkg::cmd_t                   cmd,
  output mrq_pkg::status_t                status
);
  import mrq_pkg::*;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int TASK_W = $clog2(MAX_TASKS);

  logic [ID_W-1:0]   head_mem [NUM_LEVELS];
  logic [ID_W-1:0]   tail_mem [NUM_LEVELS];
  logic [ID_W-1:0]   link_mem [MAX_TASKS];

  logic [NUM_LEVELS-1:0] nonempty;
  logic [ID_W-1:0]       in_task;
  logic [PRIO_W-1:0]     in_prio;
  logic [LVL_W-1:0]      in_lvl;
  logic [LVL_W-1:0]      enc_lvl;
  logic                  enc_any;
  logic [LVL_W-1:0]      rd_lvl;

  logic [LVL_W-1:0]      lvl_q;
  logic [ID_W-1:0]       task_q;
  logic                  ins_ok_q;
  logic                  found_q;
  logic [ID_W-1:0]       head_rd;
  logic [ID_W-1:0]       tail_rd;
  logic [ID_W-1:0]       link_rd;

  logic                  head_we;
  logic [ID_W-1:0]       head_wd;
  logic                  tail_we;
  logic                  link_we;
  logic                  ne_set;
  logic                  ne_clr;
  logic                  last_node;

  logic                  out_valid;
  logic [ID_W-1:0]       out_task;
  logic                  out_found;

  assign in_task = s_tdata[ID_W-1:0];
  assign in_prio = s_tdata[ID_W +: PRIO_W];
  assign in_lvl  = LVL_W'(in_prio);

  // Lowest-numbered non-empty level is the most urgent one.
  always_comb begin
    enc_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        enc_lvl = LVL_W'(i);
      end
    end
  end

  assign enc_any = |nonempty;

  // On accept the memories are read at the insert level or the encoded
  // dequeue level; data is ready the following cycle, then lvl_q holds it.
  always_comb begin
    if (cmd.accept) begin
      rd_lvl = (s_tuser == OP_DEQUEUE) ? enc_lvl : in_lvl;
    end else begin
      rd_lvl = lvl_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lvl_q    <= rd_lvl;
      task_q   <= in_task;
      ins_ok_q <= (int'(in_prio) < NUM_LEVELS) && (int'(in_task) < MAX_TASKS);
      found_q  <= enc_any;
    end
  end

  assign last_node = (head_rd == tail_rd);

  always_comb begin
    head_we = 1'b0;
    head_wd = task_q;
    tail_we = 1'b0;
    link_we = 1'b0;
    ne_set  = 1'b0;
    ne_clr  = 1'b0;
    if (cmd.ins_wr && ins_ok_q) begin
      tail_we = 1'b1;
      if (nonempty[lvl_q]) begin
        link_we = 1'b1;
      end else begin
        head_we = 1'b1;
        ne_set  = 1'b1;
      end
    end else if (cmd.deq_wr && found_q) begin
      if (last_node) begin
        ne_clr = 1'b1;
      end else begin
        head_we = 1'b1;
        head_wd = link_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_rd <= head_mem[rd_lvl];
    if (head_we) begin
      head_mem[lvl_q] <= head_wd;
    end
  end

  always_ff @(posedge clk) begin
    tail_rd <= tail_mem[rd_lvl];
    if (tail_we) begin
      tail_mem[lvl_q] <= task_q;
    end
  end

  always_ff @(posedge clk) begin
    link_rd <= link_mem[TASK_W'(head_rd)];
    if (link_we) begin
      link_mem[TASK_W'(tail_rd)] <= task_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else if (ne_set) begin
      nonempty[lvl_q] <= 1'b1;
    end else if (ne_clr) begin
      nonempty[lvl_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deq_wr) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deq_wr) begin
      out_task  <= found_q ? head_rd : '0;
      out_found <= found_q;
    end
  end

  assign m_tvalid          = out_valid;
  assign m_tdata           = M_TDATA_W'(out_task);
  assign m_tuser           = out_found;
  assign status.op_dequeue = (s_tuser == OP_DEQUEUE);
  assign status.out_free   = !out_valid || m_tready;

endmodule

FILE: rtl/multilevel_ready_queue.sv
// Top level of the multilevel ready queue of a task scheduler.
// Joins the controller (mrq_ctrl) and the datapath (mrq_datapath); uses mrq_pkg.
`timescale 1ns / 1ps
//
// The slave channel takes one command word at a time. tuser selects the
// operation: 0 appends the task in tdata at the tail of its priority level,
// 1 removes the head task of the most urgent non-empty level. An insert
// gives no result word; a dequeue gives exactly one on the master channel,
// with the task number in tdata and tuser high when a task was found
// (tuser low and tdata zero on an empty queue).
// An insert reads the tail memory at acceptance, then writes the tail and
// the link or head. A dequeue reads head and tail at acceptance, then the
// link memory, then updates the head or non-empty bit and loads the output
// register; its result word is valid once it is loaded. These serial reads
// set the sequence of steps; s_tready is high only between commands.
// The output register holds one result word; a new command is accepted while
// it waits, but a dequeue holds in its last step until that word is taken.
// Reset empties every level at once; no clearing pass is needed, since head,
// tail and link entries are used only after an insert has written them.

module multilevel_ready_queue #(
  parameter int NUM_LEVELS = mrq_pkg::NUM_LEVELS_DEF,
  parameter int MAX_TASKS  = mrq_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mrq_pkg::S_TDATA_W-1:0] s_tdata,  // task_id[5:0], priority_req[10:6]
  input  logic                          s_tuser,  // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mrq_pkg::M_TDATA_W-1:0] m_tdata,  // task_id_out[5:0]
  output logic                          m_tuser   // found
);
  import mrq_pkg::*;

  cmd_t    cmd;
  status_t status;

  mrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mrq_datapath #(
    .NUM_LEVELS (NUM_LEVELS),
    .MAX_TASKS  (MAX_TASKS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for multilevel_ready_queue: streams insert and dequeue words
// and checks every result word against a linked-list model of the priority levels.
// Depends on mrq_pkg and the RTL of the block only.

module testbench;
  import mrq_pkg::*;

  localparam int LEVELS         = NUM_LEVELS_DEF;
  localparam int TASKS          = MAX_TASKS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int IDLE_PCT       = 16;

  typedef struct packed {
    logic [ID_W-1:0] task_id;
    logic            found;
  } pop_result_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  // Model of the ready queue, updated as each word is accepted.
  logic [ID_W-1:0]   rq_head [LEVELS];
  logic [ID_W-1:0]   rq_tail [LEVELS];
  logic [LEVELS-1:0] rq_nonempty;
  logic [ID_W-1:0]   rq_link [TASKS];
  logic [TASKS-1:0]  task_queued;

  pop_result_t expected_pops[$];
  int          error_count;
  bit          idle_enabled;
  bit          hold_req;

  multilevel_ready_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function void enqueue_task(logic [ID_W-1:0] tid, logic [PRIO_W-1:0] lvl);
    if (!rq_nonempty[lvl]) begin
      rq_head[lvl]     = tid;
      rq_tail[lvl]     = tid;
      rq_nonempty[lvl] = 1'b1;
    end else begin
      rq_link[rq_tail[lvl]] = tid;
      rq_tail[lvl]          = tid;
    end
    task_queued[tid] = 1'b1;
  endfunction

  function pop_result_t pop_most_urgent();
    pop_result_t     r;
    logic [ID_W-1:0] node;
    r = '0;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      if (rq_nonempty[lvl] && !r.found) begin
        node = rq_head[lvl];
        if (node == rq_tail[lvl]) begin
          rq_nonempty[lvl] = 1'b0;
        end else begin
          rq_head[lvl] = rq_link[node];
        end
        task_queued[node] = 1'b0;
        r.task_id = node;
        r.found   = 1'b1;
      end
    end
    return r;
  endfunction

  // Offers one word, possibly after a short gap, and updates the model on acceptance.
  task automatic send_word(logic op, logic [ID_W-1:0] tid, logic [PRIO_W-1:0] lvl);
    int gap;
    gap = (idle_enabled && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_TDATA_W - ID_W - PRIO_W){1'b0}}, lvl, tid};
    do @(posedge clk); while (!s_tready);
    if (op == OP_INSERT) begin
      enqueue_task(tid, lvl);
    end else begin
      expected_pops.push_back(pop_most_urgent());
    end
  endtask

  // Inserts only tasks that are not queued yet; the ignored fields of a dequeue are random.
  task automatic send_random_item(int dequeue_pct, int narrow_pct);
    logic [ID_W-1:0]   tid;
    logic [PRIO_W-1:0] lvl;
    tid = ID_W'($urandom);
    lvl = PRIO_W'($urandom);
    if (&task_queued || $urandom_range(0, 99) < dequeue_pct) begin
      send_word(OP_DEQUEUE, tid, lvl);
    end else begin
      do tid = ID_W'($urandom_range(0, TASKS - 1)); while (task_queued[tid]);
      if ($urandom_range(0, 99) < narrow_pct) lvl = PRIO_W'($urandom_range(0, 3));
      send_word(OP_INSERT, tid, lvl);
    end
  endtask

  task automatic test_empty_queue();
    send_word(OP_DEQUEUE, '1, '1);
    send_word(OP_DEQUEUE, '0, '0);
  endtask

  task automatic test_level_extremes();
    send_word(OP_INSERT, 6'd63, 5'd31);
    send_word(OP_INSERT, 6'd0, 5'd0);
    send_word(OP_INSERT, 6'd21, 5'd31);
    send_word(OP_INSERT, 6'd42, 5'd0);
    repeat (4) send_word(OP_DEQUEUE, '0, '0);
  endtask

  // The level must empty when its only task leaves, and then take a new one.
  task automatic test_last_task_of_level();
    send_word(OP_INSERT, 6'd33, 5'd9);
    send_word(OP_DEQUEUE, '1, '0);
    send_word(OP_INSERT, 6'd34, 5'd9);
    send_word(OP_DEQUEUE, '0, '1);
  endtask

  // A task queued twice rewrites its own link; only written links are ever followed.
  task automatic test_duplicate_task();
    send_word(OP_INSERT, 6'd5, 5'd3);
    send_word(OP_INSERT, 6'd5, 5'd3);
    send_word(OP_INSERT, 6'd9, 5'd3);
    send_word(OP_DEQUEUE, '0, '0);
    send_word(OP_DEQUEUE, '0, '0);
    send_word(OP_INSERT, 6'd12, 5'd4);
    send_word(OP_INSERT, 6'd12, 5'd4);
    send_word(OP_DEQUEUE, '0, '0);
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_random_item(45, 50);
  endtask

  task automatic test_steady_stream(int count);
    idle_enabled = 1'b0;
    repeat (count) send_random_item(50, 40);
    idle_enabled = 1'b1;
  endtask

  // The receiver stalls for a long stretch while dequeues keep coming.
  task automatic test_output_backpressure();
    repeat (20) send_random_item(0, 30);
    hold_req = 1'b1;
    repeat (30) send_random_item(100, 0);
  endtask

  task automatic test_drain_bursts(int count);
    repeat (count) send_random_item(70, 60);
  endtask

  initial begin
    int held;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= idle_enabled ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pop_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pops.size() == 0) begin
        $error("result word with no dequeue pending: task_id_out %0d found %0b",
               m_tdata[ID_W-1:0], m_tuser);
        error_count++;
      end else begin
        want = expected_pops.pop_front();
        if (m_tdata[ID_W-1:0] !== want.task_id) begin
          $error("task_id_out: expected %0d, got %0d", want.task_id, m_tdata[ID_W-1:0]);
          error_count++;
        end
        if (m_tuser !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, m_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tuser      = OP_INSERT;
    s_tdata      = '0;
    error_count  = 0;
    idle_enabled = 1'b1;
    hold_req     = 1'b0;
    rq_nonempty  = '0;
    task_queued  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_level_extremes();
    test_last_task_of_level();
    test_duplicate_task();
    test_random_traffic(500);
    test_steady_stream(250);
    test_output_backpressure();
    test_drain_bursts(330);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
